/* hdl/gnss_binary_deframer_crc32_unit_assert.svh */
// Assertion macros shared by the deframer RTL; they vanish in synthesis builds.
`ifndef GNSS_BINARY_DEFRAMER_CRC32_UNIT_ASSERT_SVH
`define GNSS_BINARY_DEFRAMER_CRC32_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GBDC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbdc: same-cycle check failed");
`define GBDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbdc: next-cycle check failed");
`else
`define GBDC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define GBDC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/gbdc_pkg.sv */
// Package with the types, constants and CRC function of the binary deframer.
`timescale 1ns / 1ps
package gbdc_pkg;

   // Frame layout, in bytes counted from the first sync byte.
   localparam int LONG_HEADER_BYTES   = 28;
   localparam int SHORT_HEADER_BYTES  = 12;
   localparam int LONG_LENGTH_OFFSET  = 8;
   localparam int SHORT_LENGTH_OFFSET = 3;
   localparam int TRAILER_BYTES       = 4;

   // Depth of each of the two queues in the block.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SYNC_FIRST       = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND      = 2'd1;
   localparam logic [1:0] CSR_SYNC_THIRD_LONG  = 2'd2;
   localparam logic [1:0] CSR_SYNC_THIRD_SHORT = 2'd3;

   localparam logic [7:0] SYNC_FIRST_RESET       = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RESET      = 8'h44;
   localparam logic [7:0] SYNC_THIRD_LONG_RESET  = 8'h12;
   localparam logic [7:0] SYNC_THIRD_SHORT_RESET = 8'h13;

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_HUNT3,
      PH_HEADER,
      PH_BODY
   } phase_type;

   // What the back end does with a byte.
   typedef enum logic [1:0] {
      OP_START,
      OP_FEED,
      OP_TRAIL
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic [16:0] pos;
      logic        is_long;
      logic        last;
      logic        emit;
   } item_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic [16:0] byte_position;
      logic        is_long_header;
      logic        frame_last;
      logic        crc_ok;
   } rsp_type;

   // One byte of the reflected CRC-32 update, bit by bit.
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] w;
      w = {24'd0, crc[7:0] ^ data};
      for (int k = 0; k < 8; k++) begin
         w = w[0] ? ((w >> 1) ^ CRC_POLY) : (w >> 1);
      end
      return {8'd0, crc[31:8]} ^ w;
   endfunction

endpackage

/* hdl/gbdc_fifo.sv */
// Small register queue with a fall-through read port.
`timescale 1ns / 1ps
module gbdc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/gbdc_front.sv */
// Front end: sync hunt, header parsing, byte positions and frame end detection.
`timescale 1ns / 1ps
module gbdc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_rx_byte,
   output logic               req_full,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output logic               item_push,
   output gbdc_pkg::item_type item,
   input  logic               item_full
);

   localparam logic [17:0] LONG_HDR  = 18'(gbdc_pkg::LONG_HEADER_BYTES);
   localparam logic [17:0] SHORT_HDR = 18'(gbdc_pkg::SHORT_HEADER_BYTES);
   localparam logic [17:0] TRAILER   = 18'(gbdc_pkg::TRAILER_BYTES);
   localparam logic [16:0] LONG_OFS  = 17'(gbdc_pkg::LONG_LENGTH_OFFSET);
   localparam logic [16:0] SHORT_OFS = 17'(gbdc_pkg::SHORT_LENGTH_OFFSET);

   gbdc_pkg::phase_type phase_ff, phase_in;
   logic [16:0] count_ff, count_in;
   logic        long_ff, long_in;
   logic [15:0] body_len_ff, body_len_in;
   logic [7:0]  sync_first_ff, sync_second_ff, sync_third_long_ff, sync_third_short_ff;

   logic        accept;
   logic        push_req;
   logic        hit_first, hit_second, hit_long, hit_third;
   logic [17:0] hdr_bytes, pos_ext, pos_plus1, total;
   logic        hdr_done, body_data, at_end;

   assign req_full  = item_full;
   assign accept    = req_push && !item_full;
   assign item_push = accept && push_req;

   assign hit_first  = (req_rx_byte == sync_first_ff);
   assign hit_second = (req_rx_byte == sync_second_ff);
   assign hit_long   = (req_rx_byte == sync_third_long_ff);
   assign hit_third  = hit_long || (req_rx_byte == sync_third_short_ff);

   assign hdr_bytes = long_ff ? LONG_HDR : SHORT_HDR;
   assign pos_ext   = {1'b0, count_ff};
   assign pos_plus1 = pos_ext + 18'd1;
   assign total     = hdr_bytes + {2'b00, body_len_ff} + TRAILER;
   assign hdr_done  = (pos_plus1 >= hdr_bytes);
   assign body_data = ((pos_ext + TRAILER) < total);
   assign at_end    = (pos_plus1 >= total);

   // Next phase for the byte on the input.
   always_comb begin
      case (phase_ff)
         gbdc_pkg::PH_HUNT2: begin
            if (hit_second) phase_in = gbdc_pkg::PH_HUNT3;
            else phase_in = hit_first ? gbdc_pkg::PH_HUNT2 : gbdc_pkg::PH_HUNT1;
         end
         gbdc_pkg::PH_HUNT3: begin
            if (hit_third) phase_in = gbdc_pkg::PH_HEADER;
            else phase_in = hit_first ? gbdc_pkg::PH_HUNT2 : gbdc_pkg::PH_HUNT1;
         end
         gbdc_pkg::PH_HEADER: begin
            phase_in = hdr_done ? gbdc_pkg::PH_BODY : gbdc_pkg::PH_HEADER;
         end
         gbdc_pkg::PH_BODY: begin
            phase_in = (!body_data && at_end) ? gbdc_pkg::PH_HUNT1 : gbdc_pkg::PH_BODY;
         end
         default: begin
            phase_in = hit_first ? gbdc_pkg::PH_HUNT2 : gbdc_pkg::PH_HUNT1;
         end
      endcase
   end

   // Counters, header fields and the item handed to the back end.
   always_comb begin
      count_in     = count_ff;
      long_in      = long_ff;
      body_len_in  = body_len_ff;
      push_req     = 1'b0;
      item.op      = gbdc_pkg::OP_FEED;
      item.data    = req_rx_byte;
      item.pos     = count_ff;
      item.is_long = long_ff;
      item.last    = 1'b0;
      item.emit    = 1'b0;
      case (phase_ff)
         gbdc_pkg::PH_HUNT2, gbdc_pkg::PH_HUNT3: begin
            if ((phase_ff == gbdc_pkg::PH_HUNT2) ? hit_second : hit_third) begin
               push_req = 1'b1;
               if (phase_ff == gbdc_pkg::PH_HUNT2) begin
                  count_in = 17'd2;
               end else begin
                  count_in = 17'd3;
                  long_in  = hit_long;
               end
            end else if (hit_first) begin
               // A byte that breaks the sync may itself open a new frame.
               push_req    = 1'b1;
               item.op     = gbdc_pkg::OP_START;
               count_in    = 17'd1;
               body_len_in = '0;
            end else begin
               count_in = '0;
            end
         end
         gbdc_pkg::PH_HEADER: begin
            push_req  = 1'b1;
            item.emit = 1'b1;
            count_in  = pos_plus1[16:0];
            if (long_ff) begin
               if (count_ff == LONG_OFS) body_len_in[7:0] = req_rx_byte;
               else if (count_ff == LONG_OFS + 17'd1) body_len_in[15:8] = req_rx_byte;
            end else if (count_ff == SHORT_OFS) begin
               body_len_in = {8'd0, req_rx_byte};
            end
         end
         gbdc_pkg::PH_BODY: begin
            push_req  = 1'b1;
            item.emit = 1'b1;
            count_in  = pos_plus1[16:0];
            if (!body_data) begin
               item.op = gbdc_pkg::OP_TRAIL;
               if (at_end) begin
                  item.last = 1'b1;
                  count_in  = '0;
               end
            end
         end
         default: begin
            if (hit_first) begin
               push_req    = 1'b1;
               item.op     = gbdc_pkg::OP_START;
               count_in    = 17'd1;
               body_len_in = '0;
            end else begin
               count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gbdc_pkg::PH_HUNT1;
         count_ff    <= '0;
         long_ff     <= 1'b0;
         body_len_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         long_ff     <= long_in;
         body_len_ff <= body_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff       <= gbdc_pkg::SYNC_FIRST_RESET;
         sync_second_ff      <= gbdc_pkg::SYNC_SECOND_RESET;
         sync_third_long_ff  <= gbdc_pkg::SYNC_THIRD_LONG_RESET;
         sync_third_short_ff <= gbdc_pkg::SYNC_THIRD_SHORT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            gbdc_pkg::CSR_SYNC_FIRST:      sync_first_ff       <= csr_wdata;
            gbdc_pkg::CSR_SYNC_SECOND:     sync_second_ff      <= csr_wdata;
            gbdc_pkg::CSR_SYNC_THIRD_LONG: sync_third_long_ff  <= csr_wdata;
            default:                       sync_third_short_ff <= csr_wdata;
         endcase
      end
   end

endmodule

/* hdl/gbdc_back.sv */
// Back end: running CRC-32, trailer capture and result formation.
`timescale 1ns / 1ps
module gbdc_back (
   input  logic               clock,
   input  logic               reset,
   input  gbdc_pkg::item_type item,
   input  logic               item_empty,
   output logic               item_pop,
   output logic               rsp_push,
   output gbdc_pkg::rsp_type  rsp,
   input  logic               rsp_full
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] trail_ff, trail_in;
   logic [31:0] crc_next;
   logic [31:0] trail_shift;

   // Bytes that give no result never wait on the result queue.
   assign item_pop = !item_empty && (!item.emit || !rsp_full);
   assign rsp_push = item_pop && item.emit;

   assign crc_next    = gbdc_pkg::crc_feed((item.op == gbdc_pkg::OP_START) ? 32'd0 : crc_ff,
                                           item.data);
   assign trail_shift = {item.data, trail_ff[31:8]};

   always_comb begin
      crc_in   = crc_ff;
      trail_in = trail_ff;
      case (item.op)
         gbdc_pkg::OP_START: begin
            crc_in   = crc_next;
            trail_in = '0;
         end
         gbdc_pkg::OP_FEED: begin
            crc_in = crc_next;
         end
         gbdc_pkg::OP_TRAIL: begin
            trail_in = trail_shift;
         end
         default: begin
            crc_in   = crc_ff;
            trail_in = trail_ff;
         end
      endcase
   end

   always_comb begin
      rsp.frame_byte     = item.data;
      rsp.byte_position  = item.pos;
      rsp.is_long_header = item.is_long;
      rsp.frame_last     = item.last;
      rsp.crc_ok         = item.last && (item.op == gbdc_pkg::OP_TRAIL) &&
                           (trail_shift == crc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         trail_ff <= '0;
      end else if (item_pop) begin
         crc_ff   <= crc_in;
         trail_ff <= trail_in;
      end
   end

endmodule

/* hdl/gnss_binary_deframer_crc32_unit.sv */
// Top level of the binary frame deframer with CRC-32 check.
`timescale 1ns / 1ps
`include "gnss_binary_deframer_crc32_unit_assert.svh"
// The block takes a receiver byte stream on a queue-style input (req_push, req_full,
// req_rx_byte); one byte is transferred at a rising edge with req_push high and req_full low.
// It hunts for the three-byte sync pattern, parses the header length and hands out every
// frame byte after the sync on a queue-style result port (rsp_empty, rsp_pop, rsp_*), with
// frame_last raised on the final trailer byte, and crc_ok with it when the trailer matches the CRC.
// A byte's result reaches the result port through both queues: the front end classifies the
// byte in the cycle of its transfer and writes it into a small queue, and the back end then
// takes it from there, updates the running CRC-32 and writes the result queue, after which
// rsp_empty drops. Throughput is one byte per cycle while the receiver keeps popping; the
// combinational CRC byte update in the back end and the front end's sync and length compares set it.
// When the receiver stops popping, the result queue fills, then the back end stops and the
// middle queue fills, and finally req_full rises; no byte is lost and none is repeated.
// Reset (synchronous, active high) empties both queues, returns the sync hunt to its start
// and loads the sync registers with their default values. The csr_ port writes a sync
// register at the rising edge where csr_write_en is high; writes are meant to happen while
// the block is idle.
module gnss_binary_deframer_crc32_unit #(
   parameter int QUEUE_DEPTH = gbdc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic [16:0] rsp_byte_position,
   output logic        rsp_is_long_header,
   output logic        rsp_frame_last,
   output logic        rsp_crc_ok,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   gbdc_pkg::item_type front_item, back_item;
   gbdc_pkg::rsp_type  back_rsp, out_rsp;
   logic               item_push, item_full, item_pop, item_empty;
   logic               rsp_push, rsp_full;

   // The front end only decides what each byte means; it never waits on the CRC.
   gbdc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_rx_byte  (req_rx_byte),
      .req_full     (req_full),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_push    (item_push),
      .item         (front_item),
      .item_full    (item_full)
   );

   // Sync bytes travel through this queue too, since they enter the CRC.
   gbdc_fifo #(
      .WIDTH ($bits(gbdc_pkg::item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (front_item),
      .full      (item_full),
      .pop       (item_pop),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   gbdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .rsp_push   (rsp_push),
      .rsp        (back_rsp),
      .rsp_full   (rsp_full)
   );

   // The result queue holds finished results while the receiver stalls.
   gbdc_fifo #(
      .WIDTH ($bits(gbdc_pkg::rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (out_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_frame_byte     = out_rsp.frame_byte;
   assign rsp_byte_position  = out_rsp.byte_position;
   assign rsp_is_long_header = out_rsp.is_long_header;
   assign rsp_frame_last     = out_rsp.frame_last;
   assign rsp_crc_ok         = out_rsp.crc_ok;

   // A CRC verdict is only ever given on the closing byte of a frame.
   `GBDC_ASSERT_IMPLIES(a_crc_ok_only_on_last, clock, reset, !rsp_empty && rsp_crc_ok, rsp_frame_last)
   // Sync bytes are never handed out, so every result lies past the sync pattern.
   `GBDC_ASSERT_IMPLIES(a_position_past_sync, clock, reset, !rsp_empty, rsp_byte_position >= 17'd3)
   // Reset leaves no result behind and the input open.
   `GBDC_ASSERT_NEXT(a_reset_clears_queues, clock, 1'b0, reset, rsp_empty && !req_full)

endmodule

/* tb/gbdc_frame_checker.sv */
// Checker that tracks the deframer's byte stream, predicts its results and compares them.
`timescale 1ns / 1ps
module gbdc_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_frame_byte,
   input  logic [16:0] rsp_byte_position,
   input  logic        rsp_is_long_header,
   input  logic        rsp_frame_last,
   input  logic        rsp_crc_ok,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          pending,
   output int          mismatches,
   output int          bytes_in,
   output int          results_checked,
   output int          frame_ends,
   output int          crc_fail_ends
);

   logic [7:0]  sync_first_r;
   logic [7:0]  sync_second_r;
   logic [7:0]  sync_third_long_r;
   logic [7:0]  sync_third_short_r;

   gbdc_pkg::phase_type phase;
   logic [16:0] byte_count;
   logic        long_header;
   logic [15:0] body_length;
   logic [31:0] running_crc;
   logic [31:0] trailer_word;

   gbdc_pkg::rsp_type expected_bytes[$];
   int          err_count;

   // Reflected CRC-32, one data bit per step, least significant bit first.
   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ ((r[0] ^ d[i]) ? gbdc_pkg::CRC_POLY : 32'd0);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
      err_count++;
   endtask

   // A byte that breaks the sync pattern is looked at again as a first sync byte.
   task automatic start_hunt(input logic [7:0] b);
      if (b == sync_first_r) begin
         phase        = gbdc_pkg::PH_HUNT2;
         byte_count   = 17'd1;
         running_crc  = crc_step(32'd0, b);
         body_length  = 16'd0;
         trailer_word = 32'd0;
      end else begin
         phase      = gbdc_pkg::PH_HUNT1;
         byte_count = 17'd0;
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      int      pos;
      int      hdr;
      int      total;
      logic    last;
      logic    ok;
      gbdc_pkg::rsp_type want;
      case (phase)
         gbdc_pkg::PH_HUNT2: begin
            if (b == sync_second_r) begin
               phase       = gbdc_pkg::PH_HUNT3;
               byte_count  = 17'd2;
               running_crc = crc_step(running_crc, b);
            end else begin
               start_hunt(b);
            end
         end
         gbdc_pkg::PH_HUNT3: begin
            // The long header wins when both third-byte registers hold the same value.
            if (b == sync_third_long_r || b == sync_third_short_r) begin
               long_header = (b == sync_third_long_r);
               phase       = gbdc_pkg::PH_HEADER;
               byte_count  = 17'd3;
               running_crc = crc_step(running_crc, b);
            end else begin
               start_hunt(b);
            end
         end
         gbdc_pkg::PH_HEADER, gbdc_pkg::PH_BODY: begin
            pos  = int'(byte_count);
            hdr  = long_header ? gbdc_pkg::LONG_HEADER_BYTES : gbdc_pkg::SHORT_HEADER_BYTES;
            last = 1'b0;
            ok   = 1'b0;
            if (phase == gbdc_pkg::PH_HEADER) begin
               if (long_header) begin
                  if (pos == gbdc_pkg::LONG_LENGTH_OFFSET) begin
                     body_length[7:0] = b;
                  end else if (pos == gbdc_pkg::LONG_LENGTH_OFFSET + 1) begin
                     body_length[15:8] = b;
                  end
               end else if (pos == gbdc_pkg::SHORT_LENGTH_OFFSET) begin
                  body_length = {8'd0, b};
               end
               running_crc = crc_step(running_crc, b);
               if (pos + 1 >= hdr) begin
                  phase = gbdc_pkg::PH_BODY;
               end
            end else begin
               total = hdr + int'(body_length) + gbdc_pkg::TRAILER_BYTES;
               if (pos + gbdc_pkg::TRAILER_BYTES < total) begin
                  running_crc = crc_step(running_crc, b);
               end else begin
                  trailer_word = {b, trailer_word[31:8]};
                  if (pos + 1 >= total) begin
                     last = 1'b1;
                     ok   = (trailer_word == running_crc);
                  end
               end
            end
            want.frame_byte     = b;
            want.byte_position  = byte_count;
            want.is_long_header = long_header;
            want.frame_last     = last;
            want.crc_ok         = ok;
            expected_bytes      = {expected_bytes, want};
            if (last) begin
               phase      = gbdc_pkg::PH_HUNT1;
               byte_count = 17'd0;
            end else begin
               byte_count = byte_count + 17'd1;
            end
         end
         default: start_hunt(b);
      endcase
   endtask

   always @(posedge clock) begin
      gbdc_pkg::rsp_type want;
      if (reset) begin
         sync_first_r       = gbdc_pkg::SYNC_FIRST_RESET;
         sync_second_r      = gbdc_pkg::SYNC_SECOND_RESET;
         sync_third_long_r  = gbdc_pkg::SYNC_THIRD_LONG_RESET;
         sync_third_short_r = gbdc_pkg::SYNC_THIRD_SHORT_RESET;
         phase              = gbdc_pkg::PH_HUNT1;
         byte_count         = 17'd0;
         long_header        = 1'b0;
         body_length        = 16'd0;
         running_crc        = 32'd0;
         trailer_word       = 32'd0;
         expected_bytes.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               gbdc_pkg::CSR_SYNC_FIRST:       sync_first_r       = csr_wdata;
               gbdc_pkg::CSR_SYNC_SECOND:      sync_second_r      = csr_wdata;
               gbdc_pkg::CSR_SYNC_THIRD_LONG:  sync_third_long_r  = csr_wdata;
               gbdc_pkg::CSR_SYNC_THIRD_SHORT: sync_third_short_r = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            results_checked <= results_checked + 1;
            if (rsp_frame_last) begin
               frame_ends <= frame_ends + 1;
               if (!rsp_crc_ok) begin
                  crc_fail_ends <= crc_fail_ends + 1;
               end
            end
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected result, frame_byte", rsp_frame_byte, 32'd0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_frame_byte !== want.frame_byte) begin
                  report_mismatch("frame_byte", rsp_frame_byte, want.frame_byte);
               end
               if (rsp_byte_position !== want.byte_position) begin
                  report_mismatch("byte_position", rsp_byte_position, want.byte_position);
               end
               if (rsp_is_long_header !== want.is_long_header) begin
                  report_mismatch("is_long_header", rsp_is_long_header, want.is_long_header);
               end
               if (rsp_frame_last !== want.frame_last) begin
                  report_mismatch("frame_last", rsp_frame_last, want.frame_last);
               end
               if (rsp_crc_ok !== want.crc_ok) begin
                  report_mismatch("crc_ok", rsp_crc_ok, want.crc_ok);
               end
            end
         end
         if (req_push && !req_full) begin
            bytes_in <= bytes_in + 1;
            deframe_byte(req_rx_byte);
         end
      end
      pending    <= expected_bytes.size();
      mismatches <= err_count;
   end

endmodule

/* tb/tb_gnss_binary_deframer_crc32_unit.sv */
// Testbench top for the binary deframer: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_gnss_binary_deframer_crc32_unit;

   // The run is stopped here if it hangs; a correct run stays far below this even if
   // every byte met the longest idle gaps on both sides.
   localparam int CYCLE_LIMIT   = 500_000;
   // Input byte count after which the run starts no new item, directed part included.
   localparam int ITEM_COUNT    = 1050;
   // Cycles to let the block drain after the last expected result; the pipeline is two
   // stages deep with two small queues, so this leaves ample margin.
   localparam int SETTLE_CYCLES = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic [16:0] rsp_byte_position;
   logic        rsp_is_long_header;
   logic        rsp_frame_last;
   logic        rsp_crc_ok;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = gbdc_pkg::CSR_SYNC_FIRST;
   logic [7:0]  csr_wdata = 8'd0;

   // When set, neither side idles: the sender pushes every cycle and the receiver pops
   // every cycle.
   logic        quiet = 1'b0;

   // Copy of the sync registers as last written, used to build frames that the block
   // will recognize.
   logic [7:0]  sync_m[4];
   logic [7:0]  frame_buf[$];

   int          sent_count = 0;
   int          config_count = 0;
   int          cycle_count = 0;
   int          pop_hold = 0;

   int          pending;
   int          mismatches;
   int          bytes_in;
   int          results_checked;
   int          frame_ends;
   int          crc_fail_ends;

   gnss_binary_deframer_crc32_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_rx_byte        (req_rx_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_is_long_header (rsp_is_long_header),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_crc_ok         (rsp_crc_ok),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // The checker watches both channels and the register port on its own; the top reads back
   // how many results are still owed, how many mismatches were seen and the summary counts.
   gbdc_frame_checker i_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_rx_byte        (req_rx_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_is_long_header (rsp_is_long_header),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_crc_ok         (rsp_crc_ok),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .pending            (pending),
      .mismatches         (mismatches),
      .bytes_in           (bytes_in),
      .results_checked    (results_checked),
      .frame_ends         (frame_ends),
      .crc_fail_ends      (crc_fail_ends)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hang anywhere in the run ends it as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[gnss_binary_deframer_crc32_unit] ERROR");
         $finish;
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 15);
      if (r < 11) begin
         return $urandom_range(1, 3);
      end
      if (r < 15) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Payload bytes lean toward all-zero and all-one values.
   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end
      if (r == 1) begin
         return 8'hFF;
      end
      return 8'($urandom);
   endfunction

   // Reflected CRC-32 byte update, used only to build correct trailers.
   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c ^ {24'd0, d};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ gbdc_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // Result side: the receiver pops on most cycles and stalls for random stretches, so
   // the result queue fills and the back pressure reaches req_full at varied points.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_pop <= !reset;
         pop_hold = 0;
      end else if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold = pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            pop_hold = gap_length();
         end
      end
   end

   // One input transfer. An optional idle gap comes first; push then stays high until
   // the byte is taken, which is an edge where push is high and full is low.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_span(input int first, input int stop);
      for (int i = first; i < stop; i++) begin
         send_byte(frame_buf[i]);
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      frame_buf = {frame_buf, b};
   endtask

   // Builds a whole frame with the current sync bytes: sync, header with the length
   // field in place, body, and the little-endian CRC trailer (one bit flipped if bad).
   task automatic make_frame(input bit is_long, input int blen, input bit bad_crc);
      int          hdr;
      logic [31:0] c;
      frame_buf.delete();
      add_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
      add_byte(sync_m[gbdc_pkg::CSR_SYNC_SECOND]);
      add_byte(is_long ? sync_m[gbdc_pkg::CSR_SYNC_THIRD_LONG]
                       : sync_m[gbdc_pkg::CSR_SYNC_THIRD_SHORT]);
      hdr = is_long ? gbdc_pkg::LONG_HEADER_BYTES : gbdc_pkg::SHORT_HEADER_BYTES;
      for (int p = 3; p < hdr; p++) begin
         if (is_long && p == gbdc_pkg::LONG_LENGTH_OFFSET) begin
            add_byte(blen[7:0]);
         end else if (is_long && p == gbdc_pkg::LONG_LENGTH_OFFSET + 1) begin
            add_byte(blen[15:8]);
         end else if (!is_long && p == gbdc_pkg::SHORT_LENGTH_OFFSET) begin
            add_byte(blen[7:0]);
         end else begin
            add_byte(rand_byte());
         end
      end
      for (int i = 0; i < blen; i++) begin
         add_byte(rand_byte());
      end
      c = 32'd0;
      foreach (frame_buf[i]) begin
         c = crc_next(c, frame_buf[i]);
      end
      if (bad_crc) begin
         c = c ^ (32'd1 << $urandom_range(0, 31));
      end
      add_byte(c[7:0]);
      add_byte(c[15:8]);
      add_byte(c[23:16]);
      add_byte(c[31:24]);
   endtask

   task automatic send_frame(input bit is_long, input int blen, input bit bad_crc);
      make_frame(is_long, blen, bad_crc);
      send_span(0, frame_buf.size());
   endtask

   // Lets the block go idle: push drops, every owed result is popped, and a few more
   // cycles pass for bytes still inside that cause no result.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four sync registers on consecutive cycles; only called while idle.
   task automatic write_syncs(input logic [7:0] first, input logic [7:0] second,
                              input logic [7:0] third_long, input logic [7:0] third_short);
      logic [1:0] regs[4];
      logic [7:0] vals[4];
      regs = '{gbdc_pkg::CSR_SYNC_FIRST, gbdc_pkg::CSR_SYNC_SECOND,
               gbdc_pkg::CSR_SYNC_THIRD_LONG, gbdc_pkg::CSR_SYNC_THIRD_SHORT};
      vals = '{first, second, third_long, third_short};
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= regs[i];
         csr_wdata    <= vals[i];
         sync_m[regs[i]] = vals[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      config_count++;
   endtask

   // Broken sync sequences. The prefixed-frame variants rely on the first sync byte
   // differing from the others, so that it breaks the pattern and restarts the hunt.
   task automatic broken_sync();
      int         kind;
      logic [7:0] junk;
      bit         prefix_ok;
      kind = $urandom_range(0, 3);
      prefix_ok = sync_m[gbdc_pkg::CSR_SYNC_FIRST] != sync_m[gbdc_pkg::CSR_SYNC_SECOND] &&
                  sync_m[gbdc_pkg::CSR_SYNC_FIRST] != sync_m[gbdc_pkg::CSR_SYNC_THIRD_LONG] &&
                  sync_m[gbdc_pkg::CSR_SYNC_FIRST] != sync_m[gbdc_pkg::CSR_SYNC_THIRD_SHORT];
      if (kind >= 2 && !prefix_ok) begin
         kind = 0;
      end
      case (kind)
         0: begin
            send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
            do junk = rand_byte(); while (junk == sync_m[gbdc_pkg::CSR_SYNC_SECOND]);
            send_byte(junk);
         end
         1: begin
            send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
            send_byte(sync_m[gbdc_pkg::CSR_SYNC_SECOND]);
            do junk = rand_byte();
            while (junk == sync_m[gbdc_pkg::CSR_SYNC_THIRD_LONG] ||
                   junk == sync_m[gbdc_pkg::CSR_SYNC_THIRD_SHORT]);
            send_byte(junk);
         end
         2: begin
            send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
            send_frame($urandom_range(0, 1), $urandom_range(0, 12), 1'b0);
         end
         default: begin
            send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
            send_byte(sync_m[gbdc_pkg::CSR_SYNC_SECOND]);
            send_frame($urandom_range(0, 1), $urandom_range(0, 12), 1'b0);
         end
      endcase
   endtask

   // A short-header frame cut off after its length byte. The bytes that follow fill
   // the rest of it, and the hunt picks up again once its declared length is used up.
   task automatic cut_frame();
      int k;
      make_frame(1'b0, $urandom_range(0, 24), 1'b0);
      k = $urandom_range(gbdc_pkg::SHORT_LENGTH_OFFSET + 1, frame_buf.size() - 1);
      send_span(0, k);
   endtask

   task automatic random_config();
      int         r;
      logic [7:0] third;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         write_syncs(8'h00, 8'hFF, 8'h00, 8'hFF);
      end else if (r == 1) begin
         write_syncs(8'hFF, 8'h00, 8'hFF, 8'h00);
      end else if (r == 2) begin
         write_syncs(gbdc_pkg::SYNC_FIRST_RESET, gbdc_pkg::SYNC_SECOND_RESET,
                     gbdc_pkg::SYNC_THIRD_LONG_RESET, gbdc_pkg::SYNC_THIRD_SHORT_RESET);
      end else begin
         // The two third bytes are kept apart so that short frames stay short.
         third = 8'($urandom);
         write_syncs(8'($urandom), 8'($urandom), third, third ^ 8'($urandom_range(1, 255)));
      end
   endtask

   initial begin
      int r;
      int is_long;
      int blen;
      int phase_end;

      sync_m[gbdc_pkg::CSR_SYNC_FIRST]       = gbdc_pkg::SYNC_FIRST_RESET;
      sync_m[gbdc_pkg::CSR_SYNC_SECOND]      = gbdc_pkg::SYNC_SECOND_RESET;
      sync_m[gbdc_pkg::CSR_SYNC_THIRD_LONG]  = gbdc_pkg::SYNC_THIRD_LONG_RESET;
      sync_m[gbdc_pkg::CSR_SYNC_THIRD_SHORT] = gbdc_pkg::SYNC_THIRD_SHORT_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with the sync values that reset loads.
      // Stray bytes while hunting give no result.
      send_byte(8'h00);
      send_byte(8'hFF);
      // Shortest frames of both header kinds, then a short and a long frame with a bad trailer.
      send_frame(1'b0, 0, 1'b0);
      send_frame(1'b1, 0, 1'b0);
      send_frame(1'b0, 3, 1'b1);
      send_frame(1'b1, 0, 1'b1);
      // Sync broken at the second byte, then at the third.
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
      send_byte(8'h00);
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_SECOND]);
      send_byte(8'hFF);
      // A breaking byte that is itself a first sync byte starts the next frame.
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
      send_frame(1'b0, 2, 1'b0);
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_SECOND]);
      send_frame(1'b1, 2, 1'b0);
      // Both bytes of the long length field in use, and the largest short body.
      send_frame(1'b1, 258, 1'b0);
      send_frame(1'b0, 255, 1'b1);

      // Registers rewritten in the middle of a frame: the frame finishes as it began and
      // only the next sync compare sees the new values. Equal third bytes pick the long
      // header.
      make_frame(1'b0, 5, 1'b0);
      send_span(0, 10);
      settle();
      write_syncs(8'h00, 8'hFF, 8'h55, 8'h55);
      send_span(10, frame_buf.size());
      send_frame(1'b1, 4, 1'b0);

      // Registers rewritten after one sync byte: the next byte misses the new second
      // sync value and is taken as a new first sync byte.
      send_byte(sync_m[gbdc_pkg::CSR_SYNC_FIRST]);
      settle();
      write_syncs(8'hFF, 8'h00, 8'h00, 8'hFF);
      make_frame(1'b1, 6, 1'b0);
      send_span(0, frame_buf.size());
      send_frame(1'b0, 1, 1'b0);

      // Random part, in phases with a fresh register setting each; some phases run
      // without any idling.
      while (sent_count < ITEM_COUNT) begin
         settle();
         random_config();
         quiet <= ($urandom_range(0, 3) == 0);
         phase_end = sent_count + $urandom_range(100, 200);
         while (sent_count < phase_end && sent_count < ITEM_COUNT) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               is_long = $urandom_range(0, 1);
               if ($urandom_range(0, 29) == 0) begin
                  blen = is_long ? $urandom_range(100, 400) : $urandom_range(200, 255);
               end else begin
                  blen = $urandom_range(0, 24);
               end
               send_frame(is_long, blen, $urandom_range(0, 6) == 0);
            end else if (r < 80) begin
               repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            end else if (r < 92) begin
               broken_sync();
            end else begin
               cut_frame();
            end
         end
      end
      settle();

      $display("Run summary: %0d bytes transferred in, %0d results checked, %0d frames closed",
               bytes_in, results_checked, frame_ends);
      $display("(%0d of them with a CRC mismatch), over %0d sync register settings.",
               crc_fail_ends, config_count);
      if (mismatches == 0) begin
         $display("[gnss_binary_deframer_crc32_unit] OK");
      end else begin
         $display("[gnss_binary_deframer_crc32_unit] ERROR");
      end
      $finish;
   end

endmodule
